// ===== hdl/celb_pkg.sv =====
// shared constants, opcodes and state encoding for the cursor edit list buffer
package celb_pkg;

	localparam int POOL_NODES_DEF       = 4096;
	localparam int ACTION_THRESHOLD_DEF = 240;

	localparam int OP_W   = 4;
	localparam int CODE_W = 8;
	localparam int POS_W  = 13;

	typedef enum logic [OP_W-1:0] {
		OP_STORE    = 4'd0,
		OP_DELETE   = 4'd1,
		OP_DEL_ACT  = 4'd2,
		OP_WIPE     = 4'd3,
		OP_CLEAR    = 4'd4,
		OP_BACK     = 4'd5,
		OP_FORWARD  = 4'd6,
		OP_START    = 4'd7,
		OP_END      = 4'd8,
		OP_BACK_ACT = 4'd9,
		OP_FWD_ACT  = 4'd10
	} opcode_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ   = 8'b0000_0010,
		ST_EXEC   = 8'b0000_0100,
		ST_LINK   = 8'b0000_1000,
		ST_LINK2  = 8'b0001_0000,
		ST_UNLINK = 8'b0010_0000,
		ST_SETTLE = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

// ===== hdl/celb_if.sv =====
// handshake channels for edit commands and status results
interface celb_cmd_if import celb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [CODE_W-1:0] code_byte;

	modport source(output valid, output opcode, output code_byte, input ready);
	modport sink(input valid, input opcode, input code_byte, output ready);
endinterface

interface celb_rsp_if import celb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  cursor_position;
	logic [POS_W-1:0]  sequence_length;
	logic [CODE_W-1:0] cursor_code;
	logic              cursor_at_end;
	logic              status;

	modport source(output valid, output cursor_position, output sequence_length,
		output cursor_code, output cursor_at_end, output status, input ready);
	modport sink(input valid, input cursor_position, input sequence_length,
		input cursor_code, input cursor_at_end, input status, output ready);
endinterface

// ===== hdl/celb_ram.sv =====
// generic single write port ram with registered read
module celb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/cursor_edit_list_buffer.sv =====
// cursor edit list buffer top level: node pool memories and edit sequencer
// from accept to result, moves, clear, overwrite, dropped stores and unknown opcodes
// pass read, exec, settle, done; a store into an empty list adds link, others link
// and link2; delete adds unlink; delete action and wipe repeat read, exec, unlink
// per removed node; action moves read and exec per byte examined. one item at a time
// reset clears all control state; node memories need no clearing pass
module cursor_edit_list_buffer import celb_pkg::*; #(
	parameter int POOL_NODES       = POOL_NODES_DEF,
	parameter int ACTION_THRESHOLD = ACTION_THRESHOLD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	celb_cmd_if.sink     cmd,
	celb_rsp_if.source   rsp
);

	localparam int NW = $clog2(POOL_NODES);      // node address bits
	localparam int LW = $clog2(POOL_NODES + 1);  // link and count bits, holds nil
	localparam logic [LW-1:0] NIL = LW'(POOL_NODES);
	localparam logic [CODE_W-1:0] THR = CODE_W'(ACTION_THRESHOLD);

	function automatic logic is_node(input logic [LW-1:0] x);
		return x < NIL;
	endfunction

	state_t            state_q;
	opcode_t           op_q;
	logic [CODE_W-1:0] byte_q;
	logic              first_q;
	logic              ovr_q;
	logic              status_q;
	logic [LW-1:0]     head_q, tail_q, cur_q, pos_q, len_q, free_q, mark_q;
	logic [LW-1:0]     k_q, p_q, n_q;

	// memory ports
	logic              code_we, next_we, prior_we, free_we;
	logic [NW-1:0]     code_wa, next_wa, prior_wa, free_wa;
	logic [CODE_W-1:0] code_wd;
	logic [LW-1:0]     next_wd, prior_wd;
	logic [NW-1:0]     free_wd;
	logic [CODE_W-1:0] code_rd;
	logic [LW-1:0]     next_rd, prior_rd;
	logic [NW-1:0]     free_rd;
	logic [NW-1:0]     free_ra;

	logic              rsp_valid_q;
	logic [POS_W-1:0]  rsp_pos_q, rsp_len_q;
	logic [CODE_W-1:0] rsp_code_q;
	logic              rsp_end_q, rsp_status_q;

	logic              cur_v;
	logic [LW-1:0]     back_cur, fwd_cur;

	// reads always follow the cursor and the free stack top
	assign free_ra = NW'(free_q - LW'(1));
	assign cur_v   = is_node(cur_q);

	celb_ram #(.WIDTH(CODE_W), .DEPTH(POOL_NODES)) u_code (
		.clk, .we(code_we), .waddr(code_wa), .wdata(code_wd),
		.raddr(cur_q[NW-1:0]), .rdata(code_rd));
	celb_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next (
		.clk, .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(cur_q[NW-1:0]), .rdata(next_rd));
	celb_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_prior (
		.clk, .we(prior_we), .waddr(prior_wa), .wdata(prior_wd),
		.raddr(cur_q[NW-1:0]), .rdata(prior_rd));
	celb_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_free (
		.clk, .we(free_we), .waddr(free_wa), .wdata(free_wd),
		.raddr(free_ra), .rdata(free_rd));

	// cursor after one step, from the links read in the exec state
	always_comb begin
		if (!cur_v) begin
			back_cur = is_node(tail_q) ? tail_q : NIL;
		end else if (is_node(prior_rd)) begin
			back_cur = prior_rd;
		end else begin
			back_cur = cur_q;
		end
		fwd_cur = cur_v ? (is_node(next_rd) ? next_rd : NIL) : cur_q;
	end

	// memory write ports
	always_comb begin
		code_we  = 1'b0;
		code_wa  = k_q[NW-1:0];
		code_wd  = byte_q;
		next_we  = 1'b0;
		next_wa  = k_q[NW-1:0];
		next_wd  = NIL;
		prior_we = 1'b0;
		prior_wa = k_q[NW-1:0];
		prior_wd = NIL;
		free_we  = 1'b0;
		free_wa  = free_q[NW-1:0];
		free_wd  = cur_q[NW-1:0];
		case (state_q)
			ST_EXEC: begin
				// overwrite in place
				if (op_q == OP_STORE && ovr_q && cur_v) begin
					code_we = 1'b1;
					code_wa = cur_q[NW-1:0];
				end
			end
			ST_LINK: begin
				code_we  = 1'b1;
				next_we  = 1'b1;
				prior_we = 1'b1;
				if (!is_node(head_q) || !is_node(tail_q)) begin
					next_wd  = NIL;
					prior_wd = NIL;
				end else if (!cur_v) begin
					next_wd  = NIL;
					prior_wd = tail_q;
				end else begin
					next_wd  = cur_q;
					prior_wd = p_q;
				end
			end
			ST_LINK2: begin
				if (!cur_v) begin
					next_we = 1'b1;
					next_wa = tail_q[NW-1:0];
					next_wd = k_q;
				end else begin
					prior_we = 1'b1;
					prior_wa = cur_q[NW-1:0];
					prior_wd = k_q;
					if (cur_q != head_q && is_node(p_q)) begin
						next_we = 1'b1;
						next_wa = p_q[NW-1:0];
						next_wd = k_q;
					end
				end
			end
			ST_UNLINK: begin
				if (is_node(p_q)) begin
					next_we = 1'b1;
					next_wa = p_q[NW-1:0];
					next_wd = n_q;
				end
				if (is_node(n_q)) begin
					prior_we = 1'b1;
					prior_wa = n_q[NW-1:0];
					prior_wd = p_q;
				end
				free_we = free_q < NIL;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);

	// sequencer and list control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_STORE;
			byte_q   <= '0;
			first_q  <= 1'b0;
			ovr_q    <= 1'b0;
			status_q <= 1'b0;
			head_q   <= NIL;
			tail_q   <= NIL;
			cur_q    <= NIL;
			pos_q    <= '0;
			len_q    <= '0;
			free_q   <= '0;
			mark_q   <= '0;
			k_q      <= '0;
			p_q      <= '0;
			n_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ovr_q <= cfg_wdata;
			end
			// the done state loads the next result itself
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						op_q     <= opcode_t'(cmd.opcode);
						byte_q   <= cmd.code_byte;
						first_q  <= 1'b1;
						status_q <= 1'b0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					// links of the cursor node arrive next cycle
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					p_q     <= prior_rd;
					n_q     <= next_rd;
					first_q <= 1'b0;
					case (op_q)
						OP_STORE: begin
							if (ovr_q && cur_v) begin
								cur_q   <= fwd_cur;
								pos_q   <= pos_q + LW'(1);
								state_q <= ST_SETTLE;
							end else if (free_q != '0) begin
								k_q     <= LW'(free_rd);
								free_q  <= free_q - LW'(1);
								state_q <= ST_LINK;
							end else if (mark_q < NIL) begin
								k_q     <= mark_q;
								mark_q  <= mark_q + LW'(1);
								state_q <= ST_LINK;
							end else begin
								status_q <= 1'b1;
								state_q  <= ST_SETTLE;
							end
						end
						OP_DELETE, OP_WIPE: begin
							state_q <= cur_v ? ST_UNLINK : ST_SETTLE;
						end
						OP_DEL_ACT: begin
							if (cur_v && (first_q || code_rd < THR)) begin
								state_q <= ST_UNLINK;
							end else begin
								state_q <= ST_SETTLE;
							end
						end
						OP_CLEAR: begin
							head_q  <= NIL;
							tail_q  <= NIL;
							cur_q   <= NIL;
							free_q  <= '0;
							mark_q  <= '0;
							pos_q   <= '0;
							len_q   <= '0;
							state_q <= ST_SETTLE;
						end
						OP_BACK: begin
							cur_q <= back_cur;
							if ((!cur_v || is_node(prior_rd)) && pos_q != '0) begin
								pos_q <= pos_q - LW'(1);
							end
							state_q <= ST_SETTLE;
						end
						OP_FORWARD: begin
							cur_q <= fwd_cur;
							if (cur_v) begin
								pos_q <= pos_q + LW'(1);
							end
							state_q <= ST_SETTLE;
						end
						OP_START: begin
							cur_q   <= is_node(head_q) ? head_q : NIL;
							pos_q   <= '0;
							state_q <= ST_SETTLE;
						end
						OP_END: begin
							cur_q   <= NIL;
							pos_q   <= len_q;
							state_q <= ST_SETTLE;
						end
						OP_BACK_ACT: begin
							// stop on an action byte reached by the previous step
							if (first_q || code_rd < THR) begin
								cur_q <= back_cur;
								if ((!cur_v || is_node(prior_rd)) && pos_q != '0) begin
									pos_q <= pos_q - LW'(1);
								end
								if (back_cur != head_q && is_node(back_cur)) begin
									state_q <= ST_READ;
								end else begin
									state_q <= ST_SETTLE;
								end
							end else begin
								state_q <= ST_SETTLE;
							end
						end
						OP_FWD_ACT: begin
							if (first_q || code_rd < THR) begin
								cur_q <= fwd_cur;
								if (cur_v) begin
									pos_q <= pos_q + LW'(1);
								end
								state_q <= is_node(fwd_cur) ? ST_READ : ST_SETTLE;
							end else begin
								state_q <= ST_SETTLE;
							end
						end
						default: begin
							state_q <= ST_SETTLE;
						end
					endcase
				end
				ST_LINK: begin
					len_q <= len_q + LW'(1);
					pos_q <= pos_q + LW'(1);
					if (!is_node(head_q) || !is_node(tail_q)) begin
						head_q  <= k_q;
						tail_q  <= k_q;
						cur_q   <= NIL;
						state_q <= ST_SETTLE;
					end else begin
						state_q <= ST_LINK2;
					end
				end
				ST_LINK2: begin
					if (!cur_v) begin
						tail_q <= k_q;
					end else if (!(cur_q != head_q && is_node(p_q))) begin
						head_q <= k_q;
					end
					state_q <= ST_SETTLE;
				end
				ST_UNLINK: begin
					if (head_q == cur_q) begin
						head_q <= n_q;
					end
					if (tail_q == cur_q) begin
						tail_q <= p_q;
					end
					if (free_q < NIL) begin
						free_q <= free_q + LW'(1);
					end
					cur_q <= is_node(n_q) ? n_q : NIL;
					if (len_q != '0) begin
						len_q <= len_q - LW'(1);
					end
					// wipe and delete action loops fetch the next node and come back
					state_q <= (op_q == OP_DELETE) ? ST_SETTLE : ST_READ;
				end
				ST_SETTLE: begin
					// cursor byte is read during this cycle
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_pos_q    <= POS_W'(pos_q);
			rsp_len_q    <= POS_W'(len_q);
			rsp_code_q   <= cur_v ? code_rd : '0;
			rsp_end_q    <= !cur_v;
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_position = rsp_pos_q;
	assign rsp.sequence_length = rsp_len_q;
	assign rsp.cursor_code     = rsp_code_q;
	assign rsp.cursor_at_end   = rsp_end_q;
	assign rsp.status          = rsp_status_q;

endmodule
